// ===== rtl/core/tpwmlz_pkg.sv =====
// tpwmlz_pkg: types, codes and constants of the TPWM LZ decompressor.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tpwmlz_pkg;

  localparam int unsigned HDR_LEN     = 8;
  localparam int unsigned HDR_SKIP    = 4;
  localparam int unsigned FLAG_COUNT  = 8;
  localparam int unsigned LEN_BIAS    = 3;
  localparam int unsigned OFFSET_BITS = 12;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       end_of_output;
    logic       truncated;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SIZE,
    S_ZERO,
    S_LIT,
    S_COPY_RD,
    S_COPY_WR,
    S_TAIL
  } ctrl_state_e;

  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_LIT,
    EMIT_COPY,
    EMIT_ZERO,
    EMIT_TRUNC
  } emit_sel_e;

  typedef struct packed {
    logic      capture;
    logic      hdr_shift;
    logic      size_load;
    logic      flags_load;
    logic      flag_next;
    logic      pend_load;
    logic      copy_start;
    logic      mem_rd;
    emit_sel_e emit;
    logic      stream_clear;
  } dp_cmd_t;

  typedef struct packed {
    logic finished;
    logic hdr_active;
    logic hdr_final;
    logic size_zero;
    logic flags_empty;
    logic flag_bit;
    logic awaiting;
    logic last;
    logic slot_free;
    logic copy_done;
    logic eoo_next;
  } dp_sts_t;

endpackage

// ===== rtl/core/tpwmlz_ctrl.sv =====
// tpwmlz_ctrl: sequencing state machine of the TPWM LZ decompressor.
// Depends on tpwmlz_pkg; drives tpwmlz_dpath through dp_cmd_t / dp_sts_t.
`timescale 1ns / 1ps

module tpwmlz_ctrl
  import tpwmlz_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output dp_cmd_t cmd_o,
  input  dp_sts_t sts_i
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.emit = EMIT_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts_i.finished) begin
          state_d = S_TAIL;
        end else if (sts_i.hdr_active) begin
          cmd_o.hdr_shift = 1'b1;
          state_d         = sts_i.hdr_final ? S_SIZE : S_TAIL;
        end else if (sts_i.flags_empty) begin
          cmd_o.flags_load = 1'b1;
          state_d          = S_TAIL;
        end else if (!sts_i.flag_bit) begin
          cmd_o.flag_next = 1'b1;
          state_d         = S_LIT;
        end else if (!sts_i.awaiting) begin
          cmd_o.pend_load = 1'b1;
          state_d         = S_TAIL;
        end else begin
          cmd_o.copy_start = 1'b1;
          cmd_o.flag_next  = 1'b1;
          state_d          = S_COPY_RD;
        end
      end
      S_SIZE: begin
        cmd_o.size_load = 1'b1;
        state_d         = sts_i.size_zero ? S_ZERO : S_TAIL;
      end
      S_ZERO: begin
        if (sts_i.slot_free) begin
          cmd_o.emit = EMIT_ZERO;
          state_d    = S_TAIL;
        end
      end
      S_LIT: begin
        if (sts_i.slot_free) begin
          cmd_o.emit = EMIT_LIT;
          state_d    = S_TAIL;
        end
      end
      S_COPY_RD: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = S_COPY_WR;
      end
      S_COPY_WR: begin
        if (sts_i.slot_free) begin
          cmd_o.emit = EMIT_COPY;
          state_d    = (sts_i.copy_done || sts_i.eoo_next) ? S_TAIL : S_COPY_RD;
        end
      end
      S_TAIL: begin
        if (!sts_i.last) begin
          state_d = S_IDLE;
        end else if (sts_i.finished) begin
          cmd_o.stream_clear = 1'b1;
          state_d            = S_IDLE;
        end else if (sts_i.slot_free) begin
          cmd_o.emit         = EMIT_TRUNC;
          cmd_o.stream_clear = 1'b1;
          state_d            = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/tpwmlz_dpath.sv =====
// tpwmlz_dpath: stream state, history memory and output register.
// Depends on tpwmlz_pkg; commanded by tpwmlz_ctrl.
`timescale 1ns / 1ps

module tpwmlz_dpath
  import tpwmlz_pkg::*;
#(
  parameter int unsigned HISTORY_BYTES = 4096,
  parameter int unsigned SIZE_BITS     = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o,
  input  dp_cmd_t   cmd_i,
  output dp_sts_t   sts_o
);

  localparam int unsigned AW = $clog2(HISTORY_BYTES);
  localparam logic [31:0] SizeLimit = 32'((64'(1) << SIZE_BITS) - 64'(1));

  // captured input item
  logic [7:0] byte_q;
  logic       last_q;

  // stream state
  logic [3:0]           hdr_pos_q, hdr_pos_d;
  logic [31:0]          hdr_bytes_q, hdr_bytes_d;
  logic [SIZE_BITS-1:0] declared_q, declared_d;
  logic [SIZE_BITS-1:0] pc_q, pc_d;
  logic [7:0]           flag_shift_q, flag_shift_d;
  logic [3:0]           flags_left_q, flags_left_d;
  logic [7:0]           pending_q, pending_d;
  logic                 awaiting_q, awaiting_d;
  logic                 finished_q, finished_d;

  // copy engine
  logic [4:0]             len_cnt_q, len_cnt_d;
  logic [OFFSET_BITS-1:0] offset_q, offset_d;
  logic                   copy_zero_q;
  logic [7:0]             rdata_q;

  // output register
  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;

  logic [7:0] hist_mem [HISTORY_BYTES];

  logic [7:0]    b4, b5, b6, b7;
  logic [31:0]   size_raw;
  logic [SIZE_BITS-1:0] size_val;
  logic          slot_free;
  logic          eoo_next;
  logic          mem_we;
  logic [7:0]    mem_wdata;
  logic [AW-1:0] rd_addr;
  logic          copy_zero_d;

  assign b4 = hdr_bytes_q[31:24];
  assign b5 = hdr_bytes_q[23:16];
  assign b6 = hdr_bytes_q[15:8];
  assign b7 = hdr_bytes_q[7:0];

  always_comb begin
    if ((9'(b4) + 9'(b5)) > (9'(b6) + 9'(b7))) begin
      size_raw = {b7, b6, b5, b4};
    end else begin
      size_raw = hdr_bytes_q;
    end
    if (size_raw > SizeLimit) begin
      size_val = '1;
    end else begin
      size_val = size_raw[SIZE_BITS-1:0];
    end
  end

  assign slot_free = !out_valid_q || out_ready_i;
  assign eoo_next  = ({1'b0, pc_q} + (SIZE_BITS + 1)'(1)) == {1'b0, declared_q};

  assign rd_addr     = pc_q[AW-1:0] - AW'(offset_q);
  assign copy_zero_d = (offset_q == '0) || (pc_q < SIZE_BITS'(offset_q));

  always_comb begin
    sts_o.finished    = finished_q;
    sts_o.hdr_active  = (hdr_pos_q < 4'(HDR_LEN));
    sts_o.hdr_final   = (hdr_pos_q == 4'(HDR_LEN - 1));
    sts_o.size_zero   = (size_val == '0);
    sts_o.flags_empty = (flags_left_q == '0);
    sts_o.flag_bit    = flag_shift_q[7];
    sts_o.awaiting    = awaiting_q;
    sts_o.last        = last_q;
    sts_o.slot_free   = slot_free;
    sts_o.copy_done   = (len_cnt_q == 5'd1);
    sts_o.eoo_next    = eoo_next;
  end

  always_comb begin
    hdr_pos_d    = hdr_pos_q;
    hdr_bytes_d  = hdr_bytes_q;
    declared_d   = declared_q;
    pc_d         = pc_q;
    flag_shift_d = flag_shift_q;
    flags_left_d = flags_left_q;
    pending_d    = pending_q;
    awaiting_d   = awaiting_q;
    finished_d   = finished_q;
    len_cnt_d    = len_cnt_q;
    offset_d     = offset_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    mem_we       = 1'b0;
    mem_wdata    = byte_q;

    if (cmd_i.hdr_shift) begin
      if (hdr_pos_q >= 4'(HDR_SKIP)) begin
        hdr_bytes_d = {hdr_bytes_q[23:0], byte_q};
      end
      hdr_pos_d = hdr_pos_q + 4'd1;
    end
    if (cmd_i.size_load) begin
      declared_d = size_val;
    end
    if (cmd_i.flags_load) begin
      flag_shift_d = byte_q;
      flags_left_d = 4'(FLAG_COUNT);
    end
    if (cmd_i.flag_next) begin
      flag_shift_d = {flag_shift_q[6:0], 1'b0};
      if (flags_left_q != '0) begin
        flags_left_d = flags_left_q - 4'd1;
      end
    end
    if (cmd_i.pend_load) begin
      pending_d  = byte_q;
      awaiting_d = 1'b1;
    end
    if (cmd_i.copy_start) begin
      awaiting_d = 1'b0;
      len_cnt_d  = 5'(pending_q[3:0]) + 5'(LEN_BIAS);
      offset_d   = {pending_q[7:4], byte_q};
    end

    out_d.out_byte      = 8'd0;
    out_d.byte_valid    = 1'b0;
    out_d.run_last      = 1'b1;
    out_d.end_of_output = 1'b1;
    out_d.truncated     = 1'b0;
    case (cmd_i.emit)
      EMIT_NONE: begin
        out_d = out_q;
      end
      EMIT_LIT, EMIT_COPY: begin
        if (cmd_i.emit == EMIT_COPY) begin
          mem_wdata      = copy_zero_q ? 8'd0 : rdata_q;
          out_d.run_last = eoo_next || ((len_cnt_q == 5'd1) && !last_q);
          len_cnt_d      = len_cnt_q - 5'd1;
        end else begin
          out_d.run_last = eoo_next || !last_q;
        end
        out_d.out_byte      = mem_wdata;
        out_d.byte_valid    = 1'b1;
        out_d.end_of_output = eoo_next;
        out_valid_d         = 1'b1;
        mem_we              = 1'b1;
        pc_d                = pc_q + SIZE_BITS'(1);
        if (eoo_next) begin
          finished_d = 1'b1;
        end
      end
      EMIT_ZERO: begin
        out_valid_d = 1'b1;
        finished_d  = 1'b1;
      end
      EMIT_TRUNC: begin
        out_valid_d     = 1'b1;
        out_d.truncated = 1'b1;
      end
      default: begin
        out_d = out_q;
      end
    endcase

    if (cmd_i.stream_clear) begin
      hdr_pos_d    = '0;
      hdr_bytes_d  = '0;
      declared_d   = '0;
      pc_d         = '0;
      flag_shift_d = '0;
      flags_left_d = '0;
      pending_d    = '0;
      awaiting_d   = 1'b0;
      finished_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_pos_q    <= '0;
      hdr_bytes_q  <= '0;
      declared_q   <= '0;
      pc_q         <= '0;
      flag_shift_q <= '0;
      flags_left_q <= '0;
      pending_q    <= '0;
      awaiting_q   <= 1'b0;
      finished_q   <= 1'b0;
      len_cnt_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      hdr_pos_q    <= hdr_pos_d;
      hdr_bytes_q  <= hdr_bytes_d;
      declared_q   <= declared_d;
      pc_q         <= pc_d;
      flag_shift_q <= flag_shift_d;
      flags_left_q <= flags_left_d;
      pending_q    <= pending_d;
      awaiting_q   <= awaiting_d;
      finished_q   <= finished_d;
      len_cnt_q    <= len_cnt_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      byte_q <= in_data_i.in_byte;
      last_q <= in_data_i.in_last;
    end
    if (cmd_i.mem_rd) begin
      copy_zero_q <= copy_zero_d;
    end
    offset_q <= offset_d;
    out_q    <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hist_mem[pc_q[AW-1:0]] <= mem_wdata;
    end
    if (cmd_i.mem_rd) begin
      rdata_q <= hist_mem[rd_addr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_emit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit != EMIT_NONE) |-> slot_free)
    else $error("emit while output register is occupied");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q <= declared_q)
    else $error("produced count passed declared size");

  a_copy_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit == EMIT_COPY) |-> (len_cnt_q != '0))
    else $error("copy byte emitted with empty length counter");

  a_eoo_finishes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cmd_i.emit == EMIT_LIT || cmd_i.emit == EMIT_COPY) && eoo_next) |=> finished_q)
    else $error("final data byte did not finish the stream");

endmodule

// ===== rtl/core/tpwm_lz_decompressor_unit.sv =====
// tpwm_lz_decompressor_unit: top level of the TPWM LZ decompressor.
// Depends on tpwmlz_pkg; instantiates tpwmlz_ctrl and tpwmlz_dpath.
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_ready_o | in_data_i  (in_item_t)
//   out     | output    | out_valid_o/out_ready_i | out_data_o (out_item_t)
//
// Each input byte passes through the idle (capture), decode and tail states; the final
// header byte adds the size state (and the zero state with a zero size marker), literals the literal state.
// A back reference repeats a history read state, then a write state, per copied byte.
// A truncation marker leaves from the tail state; output stalls hold the sequencer.
// Reset clears all control and stream state; the history needs no clearing pass.
`timescale 1ns / 1ps

module tpwm_lz_decompressor_unit
  import tpwmlz_pkg::*;
#(
  parameter int unsigned HISTORY_BYTES = 4096,
  parameter int unsigned SIZE_BITS     = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  tpwmlz_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  tpwmlz_dpath #(
    .HISTORY_BYTES (HISTORY_BYTES),
    .SIZE_BITS     (SIZE_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
